// ===== src/spr_pkg.sv =====
package spr_pkg;

  // Table depths
  localparam int SMALL_DEPTH = 16;
  localparam int LARGE_DEPTH = 128;

  // Address and count widths follow from the depths
  localparam int SMALL_AW = (SMALL_DEPTH > 1) ? $clog2(SMALL_DEPTH) : 1;
  localparam int LARGE_AW = (LARGE_DEPTH > 1) ? $clog2(LARGE_DEPTH) : 1;
  localparam int SMALL_CW = $clog2(SMALL_DEPTH + 1);
  localparam int LARGE_CW = $clog2(LARGE_DEPTH + 1);
  localparam int SCAN_CW  = (SMALL_CW > LARGE_CW) ? SMALL_CW : LARGE_CW;

  // Field widths
  localparam int PAT_W       = 9;
  localparam int REP_W       = 16;
  localparam int SMALL_PAT_W = 4;
  localparam int SMALL_REP_W = 9;
  localparam int SMALL_ENT_W = SMALL_PAT_W + SMALL_REP_W;
  localparam int LARGE_ENT_W = PAT_W + REP_W;
  localparam int NUM_VAR     = 8;

  // Commands
  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_STORED   = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef logic [NUM_VAR-1:0][PAT_W-1:0] var_set_t;

  // Quarter turn: new (i,j) takes old (n-1-j, i)
  function automatic logic [PAT_W-1:0] rot_grid(logic [PAT_W-1:0] g, logic big);
    logic [PAT_W-1:0] r;
    r = '0;
    if (big) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          r[i*3+j] = g[(2-j)*3+i];
    end else begin
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          r[i*2+j] = g[(1-j)*2+i];
    end
    return r;
  endfunction

  // Mirror left-right: new (i,j) takes old (i, n-1-j)
  function automatic logic [PAT_W-1:0] mir_grid(logic [PAT_W-1:0] g, logic big);
    logic [PAT_W-1:0] r;
    r = '0;
    if (big) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          r[i*3+j] = g[i*3+2-j];
    end else begin
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          r[i*2+j] = g[i*2+1-j];
    end
    return r;
  endfunction

  // All eight symmetries of a square pattern
  function automatic var_set_t make_variants(logic [PAT_W-1:0] q, logic big);
    var_set_t         v;
    logic [PAT_W-1:0] g;
    g = q;
    for (int k = 0; k < 4; k++) begin
      v[2*k]   = g;
      v[2*k+1] = mir_grid(g, big);
      g        = rot_grid(g, big);
    end
    return v;
  endfunction

endpackage

// ===== src/spr_if.sv =====
interface spr_in_if import spr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic                  size_three;
  logic [PAT_W-1:0]      pattern;
  logic [REP_W-1:0]      replacement;

  modport source (output valid, cmd, size_three, pattern, replacement, input ready);
  modport sink   (input valid, cmd, size_three, pattern, replacement, output ready);
endinterface

interface spr_out_if import spr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [REP_W-1:0]  result_cells;

  modport source (output valid, status, result_cells, input ready);
  modport sink   (input valid, status, result_cells, output ready);
endinterface

// ===== src/spr_ram.sv =====
module spr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/spr_match.sv =====
// Shared compare unit: one stored pattern against all eight query symmetries
module spr_match import spr_pkg::*; (
  input  var_set_t         variants,
  input  logic [PAT_W-1:0] stored,
  output logic             hit
);

  logic [NUM_VAR-1:0] eq;

  always_comb begin
    for (int k = 0; k < NUM_VAR; k++) begin
      eq[k] = (variants[k] == stored);
    end
  end

  assign hit = |eq;

endmodule

// ===== src/symmetric_pattern_rule_table.sv =====
// Symmetric pattern rule table. Holds an ordered table of 2x2 -> 3x3 rules and
// one of 3x3 -> 4x4 rules in two rule RAMs. A store transaction appends to the
// table of its size, or reports the table full and drops the rule. A lookup
// transaction walks the table in insertion order, one rule per cycle through
// the single read port of its RAM and the shared eight-way symmetry compare,
// and returns the replacement of the first rule equal to the query under any
// rotation or reflection. A store goes through the result state to the output
// register; a lookup stops at the first hit or after the last filled entry.
// Only one transaction is in work at a time; the input is ready again once the
// result has been handed to the output register, even while that result still
// waits to be taken. The tables need no clearing after reset: each keeps a fill
// count and only entries below it are ever compared.
module symmetric_pattern_rule_table import spr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  spr_in_if.sink    in_ch,
  spr_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t              state;
  logic [SMALL_CW-1:0] small_count;
  logic [LARGE_CW-1:0] large_count;

  // Lookup context
  var_set_t            variants;
  logic                big;
  logic [SCAN_CW-1:0]  idx;
  logic [SCAN_CW-1:0]  lim;
  logic                cmp_valid;

  // Pending result and output register
  status_t             res_status;
  logic [REP_W-1:0]    res_cells;
  logic                out_valid;
  status_t             out_status;
  logic [REP_W-1:0]    out_cells;

  logic                accept;
  logic                small_room;
  logic                large_room;
  logic                small_we;
  logic                large_we;
  logic [PAT_W-1:0]    qpat;
  logic                issue;
  logic                hit;
  logic [SMALL_ENT_W-1:0] small_rd;
  logic [LARGE_ENT_W-1:0] large_rd;
  logic [PAT_W-1:0]    stored_pat;
  logic [REP_W-1:0]    stored_rep;

  assign in_ch.ready         = (state == S_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.result_cells = out_cells;

  assign small_room = (small_count < SMALL_CW'(SMALL_DEPTH));
  assign large_room = (large_count < LARGE_CW'(LARGE_DEPTH));

  // Append on store while the table has room
  assign small_we = accept && (in_ch.cmd == CMD_STORE) && !in_ch.size_three && small_room;
  assign large_we = accept && (in_ch.cmd == CMD_STORE) && in_ch.size_three && large_room;

  // Drop the unused high cells of a 2x2 query
  assign qpat = in_ch.size_three ? in_ch.pattern
                                 : {{(PAT_W-SMALL_PAT_W){1'b0}}, in_ch.pattern[SMALL_PAT_W-1:0]};

  // Read one rule per cycle while entries remain
  assign issue = (idx < lim);

  spr_ram #(.WIDTH(SMALL_ENT_W), .DEPTH(SMALL_DEPTH)) u_small_ram (
    .clk   (clk),
    .we    (small_we),
    .waddr (small_count[SMALL_AW-1:0]),
    .wdata ({in_ch.pattern[SMALL_PAT_W-1:0], in_ch.replacement[SMALL_REP_W-1:0]}),
    .raddr (idx[SMALL_AW-1:0]),
    .rdata (small_rd)
  );

  spr_ram #(.WIDTH(LARGE_ENT_W), .DEPTH(LARGE_DEPTH)) u_large_ram (
    .clk   (clk),
    .we    (large_we),
    .waddr (large_count[LARGE_AW-1:0]),
    .wdata ({in_ch.pattern, in_ch.replacement}),
    .raddr (idx[LARGE_AW-1:0]),
    .rdata (large_rd)
  );

  always_comb begin
    if (big) begin
      stored_pat = large_rd[LARGE_ENT_W-1:REP_W];
      stored_rep = large_rd[REP_W-1:0];
    end else begin
      stored_pat = {{(PAT_W-SMALL_PAT_W){1'b0}}, small_rd[SMALL_ENT_W-1:SMALL_REP_W]};
      stored_rep = {{(REP_W-SMALL_REP_W){1'b0}}, small_rd[SMALL_REP_W-1:0]};
    end
  end

  spr_match u_match (
    .variants (variants),
    .stored   (stored_pat),
    .hit      (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      small_count <= '0;
      large_count <= '0;
      cmp_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Release the output register once its result is taken, unless a new
      // result is handed over in the same cycle
      if (out_valid && out_ch.ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            res_cells <= '0;
            if (in_ch.cmd == CMD_STORE) begin
              state <= S_RESULT;
              if (in_ch.size_three) begin
                if (large_room) begin
                  large_count <= large_count + 1'b1;
                  res_status  <= ST_STORED;
                end else begin
                  res_status  <= ST_FULL;
                end
              end else begin
                if (small_room) begin
                  small_count <= small_count + 1'b1;
                  res_status  <= ST_STORED;
                end else begin
                  res_status  <= ST_FULL;
                end
              end
            end else begin
              // Lookup: latch the eight symmetries and the scan limit
              variants   <= make_variants(qpat, in_ch.size_three);
              big        <= in_ch.size_three;
              idx        <= '0;
              cmp_valid  <= 1'b0;
              res_status <= ST_NO_MATCH;
              if (in_ch.size_three) begin
                lim   <= SCAN_CW'(large_count);
                state <= (large_count == '0) ? S_RESULT : S_SCAN;
              end else begin
                lim   <= SCAN_CW'(small_count);
                state <= (small_count == '0) ? S_RESULT : S_SCAN;
              end
            end
          end
        end

        S_SCAN: begin
          // Advance the read address; the compare sees the entry addressed in the previous cycle
          if (cmp_valid && hit) begin
            res_status <= ST_MATCH;
            res_cells  <= stored_rep;
            cmp_valid  <= 1'b0;
            state      <= S_RESULT;
          end else if (!issue) begin
            res_status <= ST_NO_MATCH;
            res_cells  <= '0;
            cmp_valid  <= 1'b0;
            state      <= S_RESULT;
          end else begin
            idx       <= idx + 1'b1;
            cmp_valid <= 1'b1;
          end
        end

        S_RESULT: begin
          // Hold until the output register is free, then hand over
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_cells  <= res_cells;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
